[hw/rtl/planar_odometry_integrator_defines.svh]
// Assertion macros shared by the odometry integrator RTL.
`ifndef PLANAR_ODOMETRY_INTEGRATOR_DEFINES_SVH
`define PLANAR_ODOMETRY_INTEGRATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define POD_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define POD_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/pod_pkg.sv]
package pod_pkg;

   // CORDIC x/y datapath width (Q30 plus sign and growth)
   localparam int XY_W = 32;

   // Start value of x: limit gain compensation in Q30
   localparam logic signed [XY_W-1:0] CORDIC_GAIN = 32'sh26DD3B6A;

   // 1/(2*pi) in Q64
   localparam logic [63:0] INV_TWO_PI = 64'h28BE60DB9391054A;

   // Restoring long division, elaboration use only
   function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
      logic [63:0] q;
      logic [63:0] r;
      q = '0;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         r = {r[62:0], n[b]};
         if (r >= d) begin
            r = r - d;
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   // atan(2^-i) as a fraction of a turn, full turn = 2^64
   function automatic logic [63:0] atan_turns(int unsigned i);
      logic [63:0]  rad;
      logic [63:0]  term;
      logic [127:0] prod;
      int unsigned  k;
      if (i == 0) begin
         return 64'h1 << 61;
      end
      rad = '0;
      for (k = 0; i * (2 * k + 1) < 64; k++) begin
         term = udiv64(64'h1 << (64 - i * (2 * k + 1)), 64'(2 * k + 1));
         if ((k & 1) != 0) begin
            rad = rad - term;
         end else begin
            rad = rad + term;
         end
      end
      prod = {64'h0, rad} * {64'h0, INV_TWO_PI};
      return prod[127:64];
   endfunction

   // Table entry rounded to nearest at ab bits of angle
   function automatic logic [63:0] atan_angle(int unsigned i, int unsigned ab);
      logic [63:0] t;
      t = atan_turns(i);
      return (t + (64'h1 << (63 - ab))) >> (64 - ab);
   endfunction

endpackage

[hw/rtl/pod_cordic.sv]
module pod_cordic #(
   parameter int STEPS = 16,
   parameter int AB    = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [AB-1:0]                   angle,
   output logic                            busy,
   output logic signed [pod_pkg::XY_W-1:0] cos_out,
   output logic signed [pod_pkg::XY_W-1:0] sin_out
);
   import pod_pkg::*;

   localparam int ZW    = AB + 1;
   localparam int CNT_W = $clog2(STEPS);
   localparam logic signed [ZW-1:0] HALF        = ZW'(1) << (AB - 1);
   localparam logic signed [ZW-1:0] QUARTER     = ZW'(1) << (AB - 2);
   localparam logic signed [ZW-1:0] NEG_QUARTER = -QUARTER;

   // arctangent table, one entry per step
   logic [AB-1:0] atan_tab [STEPS];
   for (genvar g = 0; g < STEPS; g++) begin : g_atan
      localparam logic [63:0] ENTRY = atan_angle(g, AB);
      assign atan_tab[g] = ENTRY[AB-1:0];
   end

   logic                   busy_ff;
   logic [CNT_W-1:0]       cnt_ff;
   logic signed [XY_W-1:0] x_ff, y_ff, x_in, y_in;
   logic signed [ZW-1:0]   z_ff, z_in;
   logic                   flip_ff;
   logic signed [XY_W-1:0] cos_ff, sin_ff;
   logic signed [ZW-1:0]   z_raw, z_fold;
   logic                   flip_fold;
   logic signed [XY_W-1:0] dx, dy;
   logic signed [ZW-1:0]   tab_ext;
   logic                   last;

   // fold the angle into [-1/4, 1/4] turn by a half turn
   always_comb begin
      z_raw     = {angle[AB-1], angle};
      z_fold    = z_raw;
      flip_fold = 1'b0;
      if (z_raw > QUARTER) begin
         z_fold    = z_raw - HALF;
         flip_fold = 1'b1;
      end else if (z_raw < NEG_QUARTER) begin
         z_fold    = z_raw + HALF;
         flip_fold = 1'b1;
      end
   end

   // one micro-rotation
   always_comb begin
      dx      = y_ff >>> cnt_ff;
      dy      = x_ff >>> cnt_ff;
      tab_ext = {1'b0, atan_tab[cnt_ff]};
      if (!z_ff[ZW-1]) begin
         x_in = x_ff - dx;
         y_in = y_ff + dy;
         z_in = z_ff - tab_ext;
      end else begin
         x_in = x_ff + dx;
         y_in = y_ff - dy;
         z_in = z_ff + tab_ext;
      end
   end

   assign last = (cnt_ff == CNT_W'(STEPS - 1));

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + CNT_W'(1);
         if (last) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (start) begin
         x_ff    <= CORDIC_GAIN;
         y_ff    <= '0;
         z_ff    <= z_fold;
         flip_ff <= flip_fold;
      end else if (busy_ff) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
         if (last) begin
            cos_ff <= flip_ff ? -x_in : x_in;
            sin_ff <= flip_ff ? -y_in : y_in;
         end
      end
   end

   assign busy    = busy_ff;
   assign cos_out = cos_ff;
   assign sin_out = sin_ff;

endmodule

[hw/rtl/pod_sermul.sv]
module pod_sermul #(
   parameter int WA = 17,
   parameter int WB = 24
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [WA-1:0]       a_in,
   input  logic [WB-1:0]       b_in,
   output logic                busy,
   output logic [WA+WB-1:0]    prod
);
   // Signed shift-add multiplier: one bit of a per cycle, LSB first.

   localparam int CW = $clog2(WA);

   logic          busy_ff;
   logic [CW-1:0] cnt_ff;
   logic [WA-1:0] a_sr_ff;
   logic [WB-1:0] b_ff;
   logic [WB:0]   acc_ff;
   logic [WA-1:0] low_ff;
   logic [WB+1:0] pp, acc_ext, sum;
   logic          last;

   assign last = (cnt_ff == CW'(WA - 1));

   // partial product; the sign bit of a carries negative weight
   always_comb begin
      pp      = a_sr_ff[0] ? {{2{b_ff[WB-1]}}, b_ff} : '0;
      acc_ext = {acc_ff[WB], acc_ff};
      sum     = last ? (acc_ext - pp) : (acc_ext + pp);
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + CW'(1);
         if (last) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // shift registers
   always_ff @(posedge clock) begin
      if (start) begin
         a_sr_ff <= a_in;
         b_ff    <= b_in;
         acc_ff  <= '0;
      end else if (busy_ff) begin
         a_sr_ff <= a_sr_ff >> 1;
         acc_ff  <= sum[WB+1:1];
         low_ff  <= {sum[0], low_ff[WA-1:1]};
      end
   end

   assign busy = busy_ff;
   assign prod = {acc_ff[WB-1:0], low_ff};

endmodule

[hw/rtl/planar_odometry_integrator.sv]
// Items are processed one at a time: req_stall is high from item accept until the result
// is loaded into the output register, so no new item is taken while one is in progress.
// Run time is set by the bit-serial multiply of the heading step (41 bit steps)
// and by two passes of the shared CORDIC or the 17-bit multiplies beside them, one iteration or bit per cycle.
// Reset is synchronous: position, heading and all control go to zero at once.
`include "planar_odometry_integrator_defines.svh"

module planar_odometry_integrator #(
   parameter int CORDIC_STEPS = 16,
   parameter int ANGLE_BITS   = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [23:0] req_vel_forward,
   input  logic signed [23:0] req_vel_lateral,
   input  logic signed [23:0] req_vel_turn,
   input  logic [15:0]        req_elapsed_time,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_pos_x,
   output logic signed [31:0] rsp_pos_y,
   output logic [31:0]        rsp_heading_out,
   output logic signed [15:0] rsp_quat_z,
   output logic signed [15:0] rsp_quat_w
);
   import pod_pkg::*;

   localparam int RX_W  = 27;  // rotated velocity, Q16
   localparam int VEL_P = 24 + XY_W;
   localparam int HEAD_A = 41;
   localparam int HEAD_B = 65;
   localparam logic signed [17:0] Q15_MAX = 18'sd32767;
   localparam logic signed [17:0] Q15_MIN = -18'sd32768;

   typedef enum logic [2:0] {
      S_IDLE,
      S_P1,     // CORDIC on old heading, turn rate times time
      S_P2,     // velocity products, heading step product
      S_P3,     // round velocities, advance heading
      S_P4,     // position products, CORDIC on half yaw
      S_DONE
   } state_type;

   state_type state_ff;
   logic      phase_start_ff;
   logic      rsp_valid_ff;
   logic signed [31:0] rsp_pos_x_ff, rsp_pos_y_ff;
   logic [31:0]        rsp_heading_ff;
   logic signed [15:0] rsp_quat_z_ff, rsp_quat_w_ff;

   logic signed [23:0] vf_ff, vl_ff, vt_ff;
   logic [15:0]        dt_ff;
   logic [31:0]        position_x_ff, position_y_ff, heading_ff;
   logic [31:0]        position_x_in, position_y_in, heading_in;
   logic signed [RX_W-1:0] rx_ff, ry_ff, rx_in, ry_in;

   // unit handshakes
   logic cord_start, turn_start, vel_start, pos_start;
   logic cord_busy, turn_busy, fc_busy, ls_busy, fs_busy, lc_busy, head_busy;
   logic xdt_busy, ydt_busy, mult_busy_any, phase_done, out_free;
   logic [ANGLE_BITS-1:0]  cord_angle, ang_old, ang_half;
   logic [ANGLE_BITS+31:0] head_ext;
   logic signed [XY_W-1:0] cord_cos, cord_sin;

   logic [40:0]             prod_turn;
   logic [VEL_P-1:0]        prod_fc, prod_ls, prod_fs, prod_lc;
   logic [HEAD_A+HEAD_B-1:0] prod_head;
   logic [16+RX_W:0]        prod_xdt, prod_ydt;

   logic signed [39:0] turn_r;
   logic               turn_neg;
   logic [39:0]        turn_mag;
   logic [31:0]        step_m, step;
   logic signed [VEL_P:0] sum_x, sum_y;
   logic [16+RX_W:0]   rnd_x, rnd_y;
   logic [31:0]        dpos_x, dpos_y;
   logic signed [32:0] qz_sum, qw_sum;
   logic signed [17:0] qz_r, qw_r;
   logic signed [15:0] qz_sat, qw_sat;

   assign req_stall = (state_ff != S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // unit start strobes for each phase
   assign cord_start = phase_start_ff && (state_ff == S_P1 || state_ff == S_P4);
   assign turn_start = phase_start_ff && (state_ff == S_P1);
   assign vel_start  = phase_start_ff && (state_ff == S_P2);
   assign pos_start  = phase_start_ff && (state_ff == S_P4);

   assign mult_busy_any = turn_busy | fc_busy | ls_busy | fs_busy | lc_busy | head_busy
                        | xdt_busy | ydt_busy;
   assign phase_done    = !phase_start_ff && !cord_busy && !mult_busy_any;

   // heading as CORDIC angle: full yaw, and half yaw (33-bit angle)
   assign head_ext   = {heading_ff, {ANGLE_BITS{1'b0}}};
   assign ang_old    = head_ext[ANGLE_BITS+31:32];
   assign ang_half   = {1'b0, head_ext[ANGLE_BITS+31:33]};
   assign cord_angle = (state_ff == S_P1) ? ang_old : ang_half;

   pod_cordic #(.STEPS(CORDIC_STEPS), .AB(ANGLE_BITS)) u_cordic (
      .clock(clock), .reset(reset), .start(cord_start), .angle(cord_angle),
      .busy(cord_busy), .cos_out(cord_cos), .sin_out(cord_sin)
   );

   pod_sermul #(.WA(17), .WB(24)) u_turn (
      .clock(clock), .reset(reset), .start(turn_start),
      .a_in({1'b0, dt_ff}), .b_in(vt_ff), .busy(turn_busy), .prod(prod_turn)
   );

   pod_sermul #(.WA(24), .WB(XY_W)) u_fc (
      .clock(clock), .reset(reset), .start(vel_start),
      .a_in(vf_ff), .b_in(cord_cos), .busy(fc_busy), .prod(prod_fc)
   );

   pod_sermul #(.WA(24), .WB(XY_W)) u_ls (
      .clock(clock), .reset(reset), .start(vel_start),
      .a_in(vl_ff), .b_in(cord_sin), .busy(ls_busy), .prod(prod_ls)
   );

   pod_sermul #(.WA(24), .WB(XY_W)) u_fs (
      .clock(clock), .reset(reset), .start(vel_start),
      .a_in(vf_ff), .b_in(cord_sin), .busy(fs_busy), .prod(prod_fs)
   );

   pod_sermul #(.WA(24), .WB(XY_W)) u_lc (
      .clock(clock), .reset(reset), .start(vel_start),
      .a_in(vl_ff), .b_in(cord_cos), .busy(lc_busy), .prod(prod_lc)
   );

   // heading step magnitude times 1/(2*pi)
   assign turn_r   = prod_turn[39:0];
   assign turn_neg = turn_r[39];
   assign turn_mag = turn_neg ? (40'd0 - turn_r) : turn_r;

   pod_sermul #(.WA(HEAD_A), .WB(HEAD_B)) u_head (
      .clock(clock), .reset(reset), .start(vel_start),
      .a_in({1'b0, turn_mag}), .b_in({1'b0, INV_TWO_PI}), .busy(head_busy),
      .prod(prod_head)
   );

   pod_sermul #(.WA(17), .WB(RX_W)) u_xdt (
      .clock(clock), .reset(reset), .start(pos_start),
      .a_in({1'b0, dt_ff}), .b_in(rx_ff), .busy(xdt_busy), .prod(prod_xdt)
   );

   pod_sermul #(.WA(17), .WB(RX_W)) u_ydt (
      .clock(clock), .reset(reset), .start(pos_start),
      .a_in({1'b0, dt_ff}), .b_in(ry_ff), .busy(ydt_busy), .prod(prod_ydt)
   );

   // rotated velocity rounded to Q16
   always_comb begin
      sum_x = {prod_fc[VEL_P-1], prod_fc} - {prod_ls[VEL_P-1], prod_ls}
            + (VEL_P+1)'(33'sh20000000);
      sum_y = {prod_fs[VEL_P-1], prod_fs} + {prod_lc[VEL_P-1], prod_lc}
            + (VEL_P+1)'(33'sh20000000);
      rx_in = sum_x[VEL_P:30];
      ry_in = sum_y[VEL_P:30];
   end

   // heading step, magnitude rounded half away from zero
   always_comb begin
      step_m     = prod_head[95:64] + {31'b0, prod_head[63]};
      step       = turn_neg ? (32'd0 - step_m) : step_m;
      heading_in = heading_ff + step;
   end

   // position step rounded to Q16.16, added modulo 2^32
   always_comb begin
      rnd_x         = prod_xdt + (17 + RX_W)'(32768);
      rnd_y         = prod_ydt + (17 + RX_W)'(32768);
      dpos_x        = {{(31 - RX_W){rnd_x[16+RX_W]}}, rnd_x[16+RX_W:16]};
      dpos_y        = {{(31 - RX_W){rnd_y[16+RX_W]}}, rnd_y[16+RX_W:16]};
      position_x_in = position_x_ff + dpos_x;
      position_y_in = position_y_ff + dpos_y;
   end

   // quaternion: Q30 to Q15 with rounding and saturation
   always_comb begin
      qz_sum = {cord_sin[XY_W-1], cord_sin} + 33'sd16384;
      qw_sum = {cord_cos[XY_W-1], cord_cos} + 33'sd16384;
      qz_r   = qz_sum[32:15];
      qw_r   = qw_sum[32:15];
      if (qz_r > Q15_MAX) begin
         qz_sat = 16'sh7FFF;
      end else if (qz_r < Q15_MIN) begin
         qz_sat = 16'sh8000;
      end else begin
         qz_sat = qz_r[15:0];
      end
      if (qw_r > Q15_MAX) begin
         qw_sat = 16'sh7FFF;
      end else if (qw_r < Q15_MIN) begin
         qw_sat = 16'sh8000;
      end else begin
         qw_sat = qw_r[15:0];
      end
   end

   // sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         phase_start_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         // result taken; a new one loads only from the final phase
         if (rsp_valid_ff && !rsp_stall && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               phase_start_ff <= req_valid;
               if (req_valid) begin
                  state_ff <= S_P1;
               end
            end
            S_P1: begin
               phase_start_ff <= phase_done;
               if (phase_done) begin
                  state_ff <= S_P2;
               end
            end
            S_P2: begin
               phase_start_ff <= 1'b0;
               if (phase_done) begin
                  state_ff <= S_P3;
               end
            end
            S_P3: begin
               state_ff       <= S_P4;
               phase_start_ff <= 1'b1;
            end
            S_P4: begin
               phase_start_ff <= 1'b0;
               if (phase_done) begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               phase_start_ff <= 1'b0;
               if (out_free) begin
                  state_ff       <= S_IDLE;
                  rsp_valid_ff   <= 1'b1;
                  rsp_pos_x_ff   <= position_x_in;
                  rsp_pos_y_ff   <= position_y_in;
                  rsp_heading_ff <= heading_ff;
                  rsp_quat_z_ff  <= qz_sat;
                  rsp_quat_w_ff  <= qw_sat;
               end
            end
            default: begin
               state_ff       <= S_IDLE;
               phase_start_ff <= 1'b0;
            end
         endcase
      end
   end

   // pose state
   always_ff @(posedge clock) begin
      if (reset) begin
         position_x_ff <= '0;
         position_y_ff <= '0;
         heading_ff    <= '0;
      end else begin
         if (state_ff == S_P3) begin
            heading_ff <= heading_in;
         end
         if (state_ff == S_DONE && out_free) begin
            position_x_ff <= position_x_in;
            position_y_ff <= position_y_in;
         end
      end
   end

   // item capture and rounded velocities
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_valid) begin
         vf_ff <= req_vel_forward;
         vl_ff <= req_vel_lateral;
         vt_ff <= req_vel_turn;
         dt_ff <= req_elapsed_time;
      end
      if (state_ff == S_P3) begin
         rx_ff <= rx_in;
         ry_ff <= ry_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pos_x       = rsp_pos_x_ff;
   assign rsp_pos_y       = rsp_pos_y_ff;
   assign rsp_heading_out = rsp_heading_ff;
   assign rsp_quat_z      = rsp_quat_z_ff;
   assign rsp_quat_w      = rsp_quat_w_ff;

   // checks
   `POD_ASSERT_NXT(a_accept_busy, clock, reset, req_valid && !req_stall, req_stall, "block not busy after item accept")
   `POD_ASSERT_IMP(a_done_idle, clock, reset, state_ff == S_DONE, !cord_busy && !mult_busy_any, "unit still busy at result load")
   `POD_ASSERT_IMP(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == S_DONE, "result raised outside final phase")

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps

module testbench;

   localparam int CORDIC_STEPS = 16;
   localparam int QUIET_LIMIT  = 2000;
   localparam int SETTLE_CYCLES = 100;
   localparam int PHASE_ITEMS  = 500;

   localparam logic signed [23:0] VEL_MAX = 24'sh7FFFFF;
   localparam logic signed [23:0] VEL_MIN = 24'sh800000;
   localparam logic [15:0]        DT_MAX  = 16'hFFFF;
   // pi/2 rad/s in Q8.16
   localparam logic signed [23:0] QUARTER_RATE = 24'sd102944;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic [31:0]        heading;
      logic signed [15:0] quat_z;
      logic signed [15:0] quat_w;
   } pose_type;

   // Tracks the integrated pose and holds the poses still owed by the block
   class pose_tracker_type;
      localparam longint      GAIN_Q30     = 64'sh26DD3B6A;
      localparam logic [63:0] INV_TURN_Q64 = 64'h28BE60DB9391054A;

      logic [31:0] track_x;
      logic [31:0] track_y;
      logic [31:0] track_heading;
      longint      atan_step[CORDIC_STEPS];
      pose_type    poses_due[$];
      int          mismatches;

      function new();
         logic [63:0]  turns;
         logic [63:0]  rad;
         logic [63:0]  term;
         logic [127:0] prod;
         // arctangent of 2^-i as a fraction of a turn, rounded to 32 bits
         for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (i == 0) begin
               turns = 64'h1 << 61;
            end else begin
               rad = '0;
               for (int k = 0; i * (2 * k + 1) < 64; k++) begin
                  term = (64'h1 << (64 - i * (2 * k + 1))) / 64'(2 * k + 1);
                  if ((k & 1) != 0) begin
                     rad = rad - term;
                  end else begin
                     rad = rad + term;
                  end
               end
               prod = {64'h0, rad} * {64'h0, INV_TURN_Q64};
               turns = prod[127:64];
            end
            atan_step[i] = longint'((turns + (64'h1 << 31)) >> 32);
         end
         track_x = '0;
         track_y = '0;
         track_heading = '0;
         mismatches = 0;
      endfunction

      function longint round_q(longint v, int sh);
         return (v + (longint'(1) << (sh - 1))) >>> sh;
      endfunction

      function logic signed [15:0] to_q15(longint v);
         longint r;
         r = round_q(v, 15);
         if (r > 32767) begin
            r = 32767;
         end else if (r < -32768) begin
            r = -32768;
         end
         return r[15:0];
      endfunction

      // Rotation-mode CORDIC on a 32-bit binary angle, Q30 results
      function void rotate(input logic [31:0] ang, output longint cosine,
                           output longint sine);
         longint z;
         longint x;
         longint y;
         longint dx;
         longint dy;
         bit     flip;
         z = longint'($signed(ang));
         x = GAIN_Q30;
         y = 0;
         flip = 1'b0;
         // fold into the right half plane, undo by negation
         if (z > (longint'(1) << 30)) begin
            z = z - (longint'(1) << 31);
            flip = 1'b1;
         end else if (z < -(longint'(1) << 30)) begin
            z = z + (longint'(1) << 31);
            flip = 1'b1;
         end
         for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x = x - dx;
               y = y + dy;
               z = z - atan_step[i];
            end else begin
               x = x + dx;
               y = y - dy;
               z = z + atan_step[i];
            end
         end
         cosine = flip ? -x : x;
         sine   = flip ? -y : y;
      endfunction

      // Advance the pose by one tick and queue the pose it should report
      function void note_tick(logic signed [23:0] vf, logic signed [23:0] vl,
                              logic signed [23:0] vt, logic [15:0] dt);
         longint       c;
         longint       s;
         longint       rx;
         longint       ry;
         longint       dt_l;
         longint       turn_rad;
         logic [63:0]  mag;
         logic [127:0] prod;
         logic [31:0]  step;
         pose_type     want;
         dt_l = longint'({48'h0, dt});
         // body velocity rotated by the heading held before the tick
         rotate(track_heading, c, s);
         rx = round_q(longint'(vf) * c - longint'(vl) * s, 30);
         ry = round_q(longint'(vf) * s + longint'(vl) * c, 30);
         track_x = track_x + 32'(round_q(rx * dt_l, 16));
         track_y = track_y + 32'(round_q(ry * dt_l, 16));
         // radians in Q32 to binary angle, magnitude rounded half away from zero
         turn_rad = longint'(vt) * dt_l;
         mag = turn_rad < 0 ? 64'(-turn_rad) : 64'(turn_rad);
         prod = {64'h0, mag} * {64'h0, INV_TURN_Q64};
         step = prod[95:64] + {31'h0, prod[63]};
         track_heading = turn_rad < 0 ? track_heading - step : track_heading + step;
         // half yaw: heading read as a 33-bit angle
         rotate({1'b0, track_heading[31:1]}, c, s);
         want.pos_x   = track_x;
         want.pos_y   = track_y;
         want.heading = track_heading;
         want.quat_z  = to_q15(s);
         want.quat_w  = to_q15(c);
         poses_due.push_back(want);
      endfunction

      function void check_pose(pose_type got);
         pose_type want;
         if (poses_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected pose x=%0d y=%0d hdg=%h z=%0d w=%0d", got.pos_x,
                        got.pos_y, got.heading, got.quat_z, got.quat_w);
            end
            return;
         end
         want = poses_due.pop_front();
         if (got.pos_x !== want.pos_x || got.pos_y !== want.pos_y ||
             got.heading !== want.heading || got.quat_z !== want.quat_z ||
             got.quat_w !== want.quat_w) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("pose mismatch at %0t", $realtime);
               $display("  expected x=%0d y=%0d hdg=%h z=%0d w=%0d", want.pos_x,
                        want.pos_y, want.heading, want.quat_z, want.quat_w);
               $display("  actual   x=%0d y=%0d hdg=%h z=%0d w=%0d", got.pos_x,
                        got.pos_y, got.heading, got.quat_z, got.quat_w);
            end
         end
      endfunction

      function int pending();
         return poses_due.size();
      endfunction
   endclass

   logic               clock;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [23:0] req_vel_forward = '0;
   logic signed [23:0] req_vel_lateral = '0;
   logic signed [23:0] req_vel_turn = '0;
   logic [15:0]        req_elapsed_time = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_pos_x;
   logic signed [31:0] rsp_pos_y;
   logic [31:0]        rsp_heading_out;
   logic signed [15:0] rsp_quat_z;
   logic signed [15:0] rsp_quat_w;

   pose_tracker_type odo_track;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          quiet_cycles = 0;

   planar_odometry_integrator DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_vel_forward  (req_vel_forward),
      .req_vel_lateral  (req_vel_lateral),
      .req_vel_turn     (req_vel_turn),
      .req_elapsed_time (req_elapsed_time),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pos_x        (rsp_pos_x),
      .rsp_pos_y        (rsp_pos_y),
      .rsp_heading_out  (rsp_heading_out),
      .rsp_quat_z       (rsp_quat_z),
      .rsp_quat_w       (rsp_quat_w)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Receiver back-pressure
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // Monitor: results are checked before the same edge's input is noted
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            odo_track.check_pose({rsp_pos_x, rsp_pos_y, rsp_heading_out,
                                  rsp_quat_z, rsp_quat_w});
         end
         if (req_valid && !req_stall) begin
            odo_track.note_tick(req_vel_forward, req_vel_lateral, req_vel_turn,
                                req_elapsed_time);
         end
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // Watchdog on cycles without any handshake
   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("testbench: errors");
      $finish;
   end

   // Present one tick and hold it until accepted
   task automatic send_tick(logic signed [23:0] vf, logic signed [23:0] vl,
                            logic signed [23:0] vt, logic [15:0] dt);
      int gap;
      @(negedge clock);
      gap = 0;
      if (send_idle_pct != 0 && $urandom_range(99) < 4) begin
         gap = $urandom_range(120, 1);
      end
      while (gap > 0 || $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         if (gap > 0) begin
            gap--;
         end
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_vel_forward  <= vf;
      req_vel_lateral  <= vl;
      req_vel_turn     <= vt;
      req_elapsed_time <= dt;
      do @(posedge clock); while (req_stall);
   endtask

   // Hold off until every queued pose has come back
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (odo_track.pending() != 0) @(negedge clock);
   endtask

   function automatic logic signed [23:0] pick_vel();
      logic signed [23:0] v;
      case ($urandom_range(7))
         0: v = VEL_MAX;
         1: v = VEL_MIN;
         2: v = 24'($urandom_range(1023)) - 24'sd512;
         3: v = '0;
         default: v = 24'($urandom);
      endcase
      return v;
   endfunction

   function automatic logic [15:0] pick_dt();
      logic [15:0] t;
      case ($urandom_range(7))
         0: t = '0;
         1: t = DT_MAX;
         2: t = 16'($urandom_range(255));
         default: t = 16'($urandom);
      endcase
      return t;
   endfunction

   initial begin
      odo_track = new();
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 25;
      recv_idle_pct = 72;

      // directed: zero tick, field extremes, zero elapsed time, turns
      send_tick('0, '0, '0, '0);
      send_tick(VEL_MAX, '0, '0, DT_MAX);
      send_tick(VEL_MIN, '0, '0, DT_MAX);
      send_tick('0, VEL_MAX, '0, DT_MAX);
      send_tick('0, VEL_MIN, '0, DT_MAX);
      send_tick(VEL_MAX, VEL_MIN, VEL_MAX, '0);
      send_tick(VEL_MAX, VEL_MAX, VEL_MAX, DT_MAX);
      send_tick(VEL_MIN, VEL_MIN, VEL_MIN, DT_MAX);
      send_tick(24'sd1, 24'sd1, 24'sd1, 16'd1);
      send_tick(-24'sd1, -24'sd1, -24'sd1, 16'd1);
      repeat (5) send_tick(24'sd65536, '0, QUARTER_RATE, DT_MAX);
      repeat (3) send_tick('0, 24'sd65536, -QUARTER_RATE, DT_MAX);
      send_tick(VEL_MAX, VEL_MAX, VEL_MIN, DT_MAX);
      send_tick(VEL_MIN, VEL_MAX, VEL_MAX, 16'h8000);
      wait_drained();

      // random ticks under three idling patterns
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_idle_pct = 25; recv_idle_pct = 72; end
            1: begin send_idle_pct = 72; recv_idle_pct = 25; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         repeat (PHASE_ITEMS) begin
            send_tick(pick_vel(), pick_vel(), pick_vel(), pick_dt());
            if ($urandom_range(99) == 0) begin
               wait_drained();
            end
         end
         wait_drained();
      end

      repeat (SETTLE_CYCLES) @(negedge clock);
      if (odo_track.mismatches == 0 && odo_track.pending() == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/pod_pkg.sv
hw/rtl/pod_cordic.sv
hw/rtl/pod_sermul.sv
hw/rtl/planar_odometry_integrator.sv
bench/testbench.sv
